>>> sv/assert_macros.svh
// Assertion macros used by the span generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FCSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FCSG_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cause) |=> (effect)) else $error(msg);
`else
`define FCSG_ASSERT(label, prop, msg)
`define FCSG_ASSERT_NEXT(label, cause, effect, msg)
`endif

`endif

>>> sv/fcsg_pkg.sv
// Shared constants and types of the filled circle span generator.
package fcsg_pkg;

    localparam int MAX_RADIUS    = 31;
    localparam int RADIUS_BITS   = 5;
    localparam int COORD_BITS    = 12;
    localparam int SPAN_BITS     = 13;
    localparam int COLOR_BITS    = 8;
    localparam int ROW_BITS      = RADIUS_BITS + 1;

    // Square root: two radicand bits retire one root bit per step.
    localparam int ROOT_BITS     = RADIUS_BITS;
    localparam int RADICAND_BITS = 2 * ROOT_BITS;
    localparam int ROOT_STEPS    = ROOT_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);
    localparam int ROOT_REM_BITS = ROOT_BITS + 2;

    // Coordinate adders: three lanes, one digit per step, low digit first.
    localparam int DIGIT_BITS    = 7;
    localparam int ADD_STEPS     = 2;
    localparam int ADD_WIDTH     = DIGIT_BITS * ADD_STEPS;
    localparam int ADD_CNT_BITS  = (ADD_STEPS > 1) ? $clog2(ADD_STEPS) : 1;
    localparam int LANES         = 3;
    localparam int LANE_ROW      = 0;
    localparam int LANE_LEFT     = 1;
    localparam int LANE_RIGHT    = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_ADD,
        ST_EMIT
    } gen_state_t;

endpackage

>>> sv/fcsg_root.sv
// Digit-serial integer square root, one root bit per cycle.
module fcsg_root (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [fcsg_pkg::RADICAND_BITS-1:0]  radicand,
    output logic [fcsg_pkg::ROOT_BITS-1:0]      root,
    output fcsg_pkg::unit_status_t              status
);

    logic [fcsg_pkg::RADICAND_BITS-1:0] radicand_reg;
    logic [fcsg_pkg::ROOT_REM_BITS-1:0] rem_reg;
    logic [fcsg_pkg::ROOT_BITS-1:0]     root_reg;
    logic [fcsg_pkg::ROOT_CNT_BITS-1:0] count_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [fcsg_pkg::ROOT_REM_BITS+1:0] rem_wide;
    logic [fcsg_pkg::ROOT_REM_BITS+1:0] trial;
    logic                               fits;
    logic                               last_step;

    // Bring down the next pair of radicand bits and try a one in the next root bit.
    assign rem_wide  = {rem_reg, radicand_reg[fcsg_pkg::RADICAND_BITS-1 -: 2]};
    assign trial     = {{(fcsg_pkg::ROOT_REM_BITS + 2 - fcsg_pkg::ROOT_BITS - 2){1'b0}},
                        root_reg, 2'b01};
    assign fits      = rem_wide >= trial;
    assign last_step = count_reg == fcsg_pkg::ROOT_CNT_BITS'(fcsg_pkg::ROOT_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg  <= !last_step;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            radicand_reg <= radicand;
            rem_reg      <= '0;
            root_reg     <= '0;
        end
        else if (busy_reg)
        begin
            radicand_reg <= {radicand_reg[fcsg_pkg::RADICAND_BITS-3:0], 2'b00};
            if (fits)
            begin
                rem_reg <= fcsg_pkg::ROOT_REM_BITS'(rem_wide - trial);
            end
            else
            begin
                rem_reg <= fcsg_pkg::ROOT_REM_BITS'(rem_wide);
            end
            root_reg <= {root_reg[fcsg_pkg::ROOT_BITS-2:0], fits};
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> sv/fcsg_span_adder.sv
// Three digit-serial adders that form the row and the two end columns of a span.
module fcsg_span_adder (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    start,
    input  logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0]     op_a,
    input  logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0]     op_b,
    input  logic [fcsg_pkg::LANES-1:0]                              carry_in,
    output logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0]     sum,
    output fcsg_pkg::unit_status_t                                  status
);

    logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0] a_reg;
    logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0] b_reg;
    logic [fcsg_pkg::LANES-1:0][fcsg_pkg::ADD_WIDTH-1:0] sum_reg;
    logic [fcsg_pkg::LANES-1:0]                          carry_reg;
    logic [fcsg_pkg::ADD_CNT_BITS-1:0]                   count_reg;
    logic                                                busy_reg;
    logic                                                done_reg;

    logic [fcsg_pkg::LANES-1:0][fcsg_pkg::DIGIT_BITS:0]  digit_sum;
    logic                                                last_step;

    assign last_step = count_reg == fcsg_pkg::ADD_CNT_BITS'(fcsg_pkg::ADD_STEPS - 1);

    always_comb
    begin
        for (int i = 0; i < fcsg_pkg::LANES; i++)
        begin
            digit_sum[i] = {1'b0, a_reg[i][fcsg_pkg::DIGIT_BITS-1:0]}
                         + {1'b0, b_reg[i][fcsg_pkg::DIGIT_BITS-1:0]}
                         + {{fcsg_pkg::DIGIT_BITS{1'b0}}, carry_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg  <= !last_step;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Operands shift out low digit first; each sum digit enters at the top.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg     <= op_a;
            b_reg     <= op_b;
            carry_reg <= carry_in;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < fcsg_pkg::LANES; i++)
            begin
                a_reg[i]     <= a_reg[i] >> fcsg_pkg::DIGIT_BITS;
                b_reg[i]     <= b_reg[i] >> fcsg_pkg::DIGIT_BITS;
                carry_reg[i] <= digit_sum[i][fcsg_pkg::DIGIT_BITS];
                sum_reg[i]   <= {digit_sum[i][fcsg_pkg::DIGIT_BITS-1:0],
                                 sum_reg[i][fcsg_pkg::ADD_WIDTH-1:fcsg_pkg::DIGIT_BITS]};
            end
        end
    end

    assign sum         = sum_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> sv/filled_circle_span_generator_unit.sv
// Top level of the filled circle span generator: sequencer and output register.
//
// A request on the input channel (in_valid, in_stall) carries one circle: center,
// radius and color. The block answers with 2*radius+1 span requests on the output
// channel (out_valid, out_stall), rows in order from center_y-radius to
// center_y+radius, each with its left and right column, the color, and last_span
// set on the final one. A radius of zero gives one single-pixel span.
// Each span passes in order through the bit-serial square root (one root bit per
// cycle), the coordinate adders (two 7-bit digits), and the output register; when
// the output is not stalled, the next span starts as soon as one is loaded there.
// in_stall is high while a circle is being worked on. The output register lets the
// next circle be taken while the final span still waits. When the receiver stalls,
// the span in the output register holds and the sequencer waits with the next one.
// Reset empties the output register and returns the sequencer to idle.
`include "assert_macros.svh"

module filled_circle_span_generator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0] center_y,
    input  logic [fcsg_pkg::RADIUS_BITS-1:0]       radius,
    input  logic [fcsg_pkg::COLOR_BITS-1:0]        red_in,
    input  logic [fcsg_pkg::COLOR_BITS-1:0]        green_in,
    input  logic [fcsg_pkg::COLOR_BITS-1:0]        blue_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_row,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_left,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_right,
    output logic [fcsg_pkg::COLOR_BITS-1:0]        red_out,
    output logic [fcsg_pkg::COLOR_BITS-1:0]        green_out,
    output logic [fcsg_pkg::COLOR_BITS-1:0]        blue_out,
    output logic                                   last_span
);

    localparam int ADD_W = fcsg_pkg::ADD_WIDTH;

    fcsg_pkg::gen_state_t state_reg, state_next;

    logic [fcsg_pkg::COORD_BITS-1:0]     cx_reg;
    logic [fcsg_pkg::COORD_BITS-1:0]     cy_reg;
    logic [fcsg_pkg::RADIUS_BITS-1:0]    radius_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     red_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     green_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     blue_reg;
    logic [fcsg_pkg::ROW_BITS-1:0]       row_reg, row_next;
    logic [fcsg_pkg::RADICAND_BITS-1:0]  rem_reg, rem_next;

    logic                                out_valid_reg;
    logic [fcsg_pkg::SPAN_BITS-1:0]      span_row_reg;
    logic [fcsg_pkg::SPAN_BITS-1:0]      span_left_reg;
    logic [fcsg_pkg::SPAN_BITS-1:0]      span_right_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     red_out_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     green_out_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]     blue_out_reg;
    logic                                last_span_reg;

    logic                                accept;
    logic                                out_free;
    logic                                span_load;
    logic                                last_row;
    logic [fcsg_pkg::RADIUS_BITS-1:0]    radius_sat;
    logic [fcsg_pkg::ROW_BITS:0]         odd_step;
    logic [fcsg_pkg::RADICAND_BITS:0]    rem_step;

    logic                                root_start;
    logic [fcsg_pkg::RADICAND_BITS-1:0]  root_radicand;
    logic [fcsg_pkg::ROOT_BITS-1:0]      root_value;
    fcsg_pkg::unit_status_t              root_status;

    logic                                add_start;
    logic [fcsg_pkg::LANES-1:0][ADD_W-1:0] add_a;
    logic [fcsg_pkg::LANES-1:0][ADD_W-1:0] add_b;
    logic [fcsg_pkg::LANES-1:0]            add_cin;
    logic [fcsg_pkg::LANES-1:0][ADD_W-1:0] add_sum;
    fcsg_pkg::unit_status_t              add_status;

    assign in_stall   = state_reg != fcsg_pkg::ST_IDLE;
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign radius_sat = (radius > fcsg_pkg::RADIUS_BITS'(fcsg_pkg::MAX_RADIUS))
                      ? fcsg_pkg::RADIUS_BITS'(fcsg_pkg::MAX_RADIUS) : radius;
    assign last_row   = row_reg == {1'b0, radius_reg};

    // Moving to the next row lowers r*r - y*y by 2y+1, so no squares are formed.
    assign odd_step = {row_reg, 1'b1};
    assign rem_step = {1'b0, rem_reg}
                    - {{(fcsg_pkg::RADICAND_BITS - fcsg_pkg::ROW_BITS){odd_step[fcsg_pkg::ROW_BITS]}},
                       odd_step};

    always_comb
    begin
        add_a[fcsg_pkg::LANE_ROW]   = ADD_W'($signed(cy_reg));
        add_b[fcsg_pkg::LANE_ROW]   = ADD_W'($signed(row_reg));
        add_cin[fcsg_pkg::LANE_ROW] = 1'b0;
        add_a[fcsg_pkg::LANE_LEFT]   = ADD_W'($signed(cx_reg));
        add_b[fcsg_pkg::LANE_LEFT]   = ~{{(ADD_W - fcsg_pkg::ROOT_BITS){1'b0}}, root_value};
        add_cin[fcsg_pkg::LANE_LEFT] = 1'b1;
        add_a[fcsg_pkg::LANE_RIGHT]   = ADD_W'($signed(cx_reg));
        add_b[fcsg_pkg::LANE_RIGHT]   = {{(ADD_W - fcsg_pkg::ROOT_BITS){1'b0}}, root_value};
        add_cin[fcsg_pkg::LANE_RIGHT] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcsg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        root_start    = 1'b0;
        root_radicand = rem_step[fcsg_pkg::RADICAND_BITS-1:0];
        add_start     = 1'b0;
        span_load     = 1'b0;
        row_next      = row_reg;
        rem_next      = rem_reg;
        unique case (state_reg) inside
            fcsg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // The top row has nothing left under the root.
                    root_start    = 1'b1;
                    root_radicand = '0;
                    row_next      = fcsg_pkg::ROW_BITS'(-{1'b0, radius_sat});
                    rem_next      = '0;
                    state_next    = fcsg_pkg::ST_ROOT;
                end
            end
            fcsg_pkg::ST_ROOT:
            begin
                if (root_status.done)
                begin
                    add_start  = 1'b1;
                    state_next = fcsg_pkg::ST_ADD;
                end
            end
            fcsg_pkg::ST_ADD, fcsg_pkg::ST_EMIT:
            begin
                if ((add_status.done || state_reg == fcsg_pkg::ST_EMIT) && out_free)
                begin
                    span_load = 1'b1;
                    if (last_row)
                    begin
                        state_next = fcsg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        root_start = 1'b1;
                        row_next   = row_reg + 1'b1;
                        rem_next   = rem_step[fcsg_pkg::RADICAND_BITS-1:0];
                        state_next = fcsg_pkg::ST_ROOT;
                    end
                end
                else if (add_status.done)
                begin
                    state_next = fcsg_pkg::ST_EMIT;
                end
            end
            default:
            begin
                state_next = fcsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        rem_reg <= rem_next;
        if (accept)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            radius_reg <= radius_sat;
            red_reg    <= red_in;
            green_reg  <= green_in;
            blue_reg   <= blue_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (span_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_load)
        begin
            span_row_reg   <= add_sum[fcsg_pkg::LANE_ROW][fcsg_pkg::SPAN_BITS-1:0];
            span_left_reg  <= add_sum[fcsg_pkg::LANE_LEFT][fcsg_pkg::SPAN_BITS-1:0];
            span_right_reg <= add_sum[fcsg_pkg::LANE_RIGHT][fcsg_pkg::SPAN_BITS-1:0];
            red_out_reg    <= red_reg;
            green_out_reg  <= green_reg;
            blue_out_reg   <= blue_reg;
            last_span_reg  <= last_row;
        end
    end

    fcsg_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (root_radicand),
        .root     (root_value),
        .status   (root_status)
    );

    fcsg_span_adder u_adder (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (add_start),
        .op_a     (add_a),
        .op_b     (add_b),
        .carry_in (add_cin),
        .sum      (add_sum),
        .status   (add_status)
    );

    assign out_valid  = out_valid_reg;
    assign span_row   = span_row_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;
    assign red_out    = red_out_reg;
    assign green_out  = green_out_reg;
    assign blue_out   = blue_out_reg;
    assign last_span  = last_span_reg;

    `FCSG_ASSERT(a_root_start_idle, root_start |-> !root_status.busy,
                 "square root restarted while busy")
    `FCSG_ASSERT(a_add_start_idle, add_start |-> (!add_status.busy && !root_status.busy),
                 "adders started while a unit is busy")
    `FCSG_ASSERT_NEXT(a_last_to_idle, span_load && last_row,
                      state_reg == fcsg_pkg::ST_IDLE && out_valid && last_span,
                      "final span did not end the circle")
    `FCSG_ASSERT(a_row_in_range,
                 (state_reg != fcsg_pkg::ST_IDLE) |->
                 ($signed(row_reg) <= $signed({1'b0, radius_reg})),
                 "row offset beyond radius")

endmodule
